/* design/fhts_pkg.sv */
`default_nettype none

package fhts_pkg;

  localparam int unsigned POS_W = 9;

  localparam logic [POS_W-1:0] POS_LIMIT    = 9'd408;
  localparam logic [POS_W-1:0] HDR_LEN      = 9'd4;
  localparam logic [POS_W-1:0] SIG_END      = 9'd14;
  localparam logic [POS_W-1:0] REGION_START = 9'd24;
  localparam logic [5:0]       STRIDE_PHASE = 6'd24;
  localparam logic [3:0]       SIG_START    = 4'd4;

  localparam logic [15:0] MAGIC_A     = 16'hFFFF;
  localparam logic [15:0] MAGIC_B     = 16'hFFFE;
  localparam logic [15:0] BOARD_LIMIT = 16'd255;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_NONE = 2'd0;
  localparam verdict_t VERDICT_A    = 2'd1;
  localparam verdict_t VERDICT_B    = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       need_boards;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [3:0][7:0]  header_bytes;
    logic             boards_required;
    logic             signature_match;
    logic             region_clean;
    logic             string_start_seen;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    position:          '0,
    header_bytes:      '0,
    boards_required:   1'b0,
    signature_match:   1'b1,
    region_clean:      1'b1,
    string_start_seen: 1'b0
  };

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h08;
      4'd1:    b = 8'h00;
      4'd2:    b = 8'h43;
      4'd3:    b = 8'h72;
      4'd4:    b = 8'h65;
      4'd5:    b = 8'h61;
      4'd6:    b = 8'h74;
      4'd7:    b = 8'h75;
      4'd8:    b = 8'h72;
      4'd9:    b = 8'h65;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

endpackage

`default_nettype wire

/* design/fhts_track.sv */
`default_nettype none

module fhts_track (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire fhts_pkg::item_t item,
  output fhts_pkg::state_t     state_nxt
);

  fhts_pkg::state_t state_r;
  fhts_pkg::state_t base;
  logic [fhts_pkg::POS_W-1:0] p;

  always_comb begin
    base = state_r;
    if (item.first_byte) begin
      base = fhts_pkg::STATE_CLEAR;
      base.boards_required = item.need_boards;
    end
    p = base.position;
    state_nxt = base;
    if (p < fhts_pkg::HDR_LEN) begin
      state_nxt.header_bytes[p[1:0]] = item.data_byte;
    end else if (p < fhts_pkg::SIG_END) begin
      if (item.data_byte != fhts_pkg::sig_byte(p[3:0] - fhts_pkg::SIG_START)) begin
        state_nxt.signature_match = 1'b0;
      end
    end
    if ((p >= fhts_pkg::REGION_START) && (p < fhts_pkg::POS_LIMIT)) begin
      if (!fhts_pkg::is_printable(item.data_byte) && (item.data_byte != 8'h00)) begin
        state_nxt.region_clean = 1'b0;
      end
      if ((p[5:0] == fhts_pkg::STRIDE_PHASE) && fhts_pkg::is_printable(item.data_byte)) begin
        state_nxt.string_start_seen = 1'b1;
      end
    end
    if (p < fhts_pkg::POS_LIMIT) begin
      state_nxt.position = p + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fhts_pkg::STATE_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.position <= fhts_pkg::POS_LIMIT)
    else $error("position past limit");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.first_byte |=> state_r.position == 9'd1)
    else $error("first byte did not restart position");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without a word");

endmodule

`default_nettype wire

/* design/fhts_judge.sv */
`default_nettype none

module fhts_judge (
  input  wire fhts_pkg::state_t  st,
  output fhts_pkg::verdict_t     verdict
);

  logic [15:0] magic;
  logic [15:0] boards;
  logic        is_a;
  logic        is_b;
  logic        hdr_ok;
  logic        sig_reject;
  logic        text_reject;

  always_comb begin
    magic       = {st.header_bytes[1], st.header_bytes[0]};
    boards      = {st.header_bytes[3], st.header_bytes[2]};
    is_a        = (magic == fhts_pkg::MAGIC_A);
    is_b        = (magic == fhts_pkg::MAGIC_B);
    hdr_ok      = (st.position >= fhts_pkg::HDR_LEN) && (is_a || is_b)
                  && (boards < fhts_pkg::BOARD_LIMIT)
                  && !(st.boards_required && (boards == 16'd0));
    sig_reject  = (st.position >= fhts_pkg::SIG_END) && is_a && st.signature_match;
    text_reject = st.region_clean && st.string_start_seen;
    if (!hdr_ok || sig_reject || text_reject) begin
      verdict = fhts_pkg::VERDICT_NONE;
    end else if (is_a) begin
      verdict = fhts_pkg::VERDICT_A;
    end else begin
      verdict = fhts_pkg::VERDICT_B;
    end
  end

endmodule

`default_nettype wire

/* design/file_header_type_sniffer.sv */
`default_nettype none

// channel | ports                                              | dir
// in      | in_valid in_ready in_data_byte in_first_byte       | in
//         | in_last_byte in_need_boards                        |
// out     | out_valid out_ready out_verdict                    | out
//
// One byte per cycle, sustained, but for the stall below; a verdict is loaded
// into the result register when its last byte leaves the input register.
// A last byte waits in the input register while the result register holds an
// unaccepted verdict, and the input stalls behind it; otherwise no stall.
// rst_n is synchronous, active low, and clears both registers' valid flags
// and the per-file tracking state.
module file_header_type_sniffer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_byte,
  input  wire logic       in_last_byte,
  input  wire logic       in_need_boards,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_verdict
);

  logic                 s1_valid_r;
  fhts_pkg::item_t      s1_item_r;
  logic                 s1_advance;
  logic                 out_free;
  logic                 out_valid_r;
  fhts_pkg::verdict_t   out_verdict_r;
  fhts_pkg::state_t     state_nxt;
  fhts_pkg::verdict_t   verdict_nxt;

  assign out_free   = !out_valid_r || out_ready;
  assign s1_advance = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_ready   = !s1_valid_r || s1_advance;

  fhts_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_advance),
    .item      (s1_item_r),
    .state_nxt (state_nxt)
  );

  fhts_judge u_judge (
    .st      (state_nxt),
    .verdict (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= '{data_byte:   in_data_byte,
                     first_byte:  in_first_byte,
                     last_byte:   in_last_byte,
                     need_boards: in_need_boards};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_advance && s1_item_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_item_r.last_byte) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r == fhts_pkg::VERDICT_NONE)
                 || (out_verdict_r == fhts_pkg::VERDICT_A)
                 || (out_verdict_r == fhts_pkg::VERDICT_B))
    else $error("illegal verdict code");

  a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_item_r.last_byte |-> s1_advance)
    else $error("non-final byte stalled");

  a_last_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_item_r.last_byte |=> out_valid_r)
    else $error("last byte produced no verdict");

endmodule

`default_nettype wire
